[src/dpsm_pkg.sv]
// dpsm_pkg: shared types and constants for the drive profile state machine.
// Holds the sub-state encoding, status codes, controlword commands and register indexes.
// No dependencies.
`default_nettype none

package dpsm_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_VELOCITY_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_TORQUE_REFERENCE = 2'd1;
  localparam logic [1:0] CFG_TOGGLE_PERIOD    = 2'd2;

  localparam int unsigned CFG_DATA_W = 31;

  // Register reset values
  localparam logic [30:0] VELOCITY_LIMIT_RST   = 31'd3000;
  localparam logic [14:0] TORQUE_REFERENCE_RST = 15'd600;
  localparam logic [15:0] TOGGLE_PERIOD_RST    = 16'd40;

  // Controlword commands
  localparam logic [15:0] CW_RESET       = 16'h0000;
  localparam logic [15:0] CW_FAULT_RESET = 16'h0080;
  localparam logic [15:0] CW_SHUTDOWN    = 16'h0006;
  localparam logic [15:0] CW_SWITCH_ON   = 16'h0007;
  localparam logic [15:0] CW_ENABLE_OP   = 16'h000F;
  localparam logic [15:0] CW_QUICK_STOP  = 16'h0002;

  // Operation modes with a transition table
  localparam logic signed [7:0] MODE_PROFILE_POS = 8'sd1;
  localparam logic signed [7:0] MODE_PROFILE_VEL = 8'sd3;

  // mode_active codes
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_POS  = 2'd1;
  localparam logic [1:0] ACT_VEL  = 2'd2;

  // State codes placed in the status word
  localparam logic [12:0] SC_SWITCH_ON_DISABLED = 13'h0260;
  localparam logic [12:0] SC_READY              = 13'h0231;
  localparam logic [12:0] SC_SWITCHED_ON        = 13'h0233;
  localparam logic [12:0] SC_OP_ENABLED         = 13'h0237;
  localparam logic [12:0] SC_RUNNING            = 13'h0637;
  localparam logic [12:0] SC_QUICK_STOP         = 13'h0617;
  localparam logic [12:0] SC_STOPPED            = 13'h0240;
  localparam logic [12:0] SC_ALT_DISABLED       = 13'h1240;
  localparam logic [12:0] SC_ALT_READY          = 13'h1231;
  localparam logic [12:0] SC_ALT_SWITCHED_ON    = 13'h1233;
  localparam logic [12:0] SC_ALT_OP_ENABLED     = 13'h1237;
  localparam logic [12:0] SC_ALT_RUNNING        = 13'h1637;

  // Sub-states, one-hot
  typedef enum logic [15:0] {
    SS_IDLE      = 16'h0001,
    SS_READY     = 16'h0002,
    SS_SW_ON     = 16'h0004,
    SS_ENABLE    = 16'h0008,
    SS_ENABLE2   = 16'h0010,
    SS_RUN       = 16'h0020,
    SS_RUN_WAIT  = 16'h0040,
    SS_STOP      = 16'h0080,
    SS_STOP2     = 16'h0100,
    SS_STOP3     = 16'h0200,
    SS_STOP4     = 16'h0400,
    SS_ALT_DIS   = 16'h0800,
    SS_ALT_READY = 16'h1000,
    SS_ALT_SW_ON = 16'h2000,
    SS_ALT_EN    = 16'h4000,
    SS_ALT_EN2   = 16'h8000
  } sub_state_t;

endpackage

`default_nettype wire

[src/drive_profile_state_machine_top.sv]
// drive_profile_state_machine_top: drive state machine with status word, toggle and
// clamped speed reference. Depends on dpsm_pkg.
`default_nettype none

// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+---------------------------------------
// in_       | input     | in_valid / in_ready  | control_word, op_mode, fault, velocity
// out_      | output    | out_valid / out_ready| status word, sends, mode, speed, run...
// cfg_      | input     | cfg_wr_en            | cfg_index, cfg_wdata (31 bit)
//
// One request per cycle while out_ready keeps up: state update and result are computed in the
// accept cycle and the result sits in the output register from the next cycle on.
// in_ready drops only while a result is held and out_ready is low; the output register
// parts the two sides so a new request is taken while the old result is being taken.
// rst_n is synchronous, active low; it clears the sub-state machine and the run state,
// presets the toggle bit and toggle count to 1 and loads the register defaults.

module drive_profile_state_machine_top
  import dpsm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_wr_en,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // request channel
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [15:0]           in_control_word,
  input  wire logic signed [7:0]     in_op_mode,
  input  wire logic                  in_fault_active,
  input  wire logic signed [31:0]    in_target_velocity,
  // result channel
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [15:0]           out_status_word,
  output      logic [1:0]            out_status_sends,
  output      logic [1:0]            out_mode_active,
  output      logic signed [7:0]     out_mode_display,
  output      logic signed [31:0]    out_speed_reference,
  output      logic                  out_drive_run,
  output      logic [14:0]           out_torque_out,
  output      logic                  out_clear_fault,
  output      logic                  out_pid_reset
);

  // Configuration registers
  logic [30:0] velocity_limit_r;
  logic [14:0] torque_reference_r;
  logic [15:0] toggle_period_r;

  // Drive state
  sub_state_t         sub_state_r,    sub_state_nxt;
  logic [12:0]        state_code_r,   state_code_nxt;
  logic               toggle_bit_r,   toggle_bit_nxt;
  logic [15:0]        toggle_count_r, toggle_count_nxt;
  logic signed [31:0] held_speed_r,   held_speed_nxt;
  logic               run_flag_r,     run_flag_nxt;

  // Output register
  logic               out_valid_r;
  logic [15:0]        status_word_r;
  logic [1:0]         status_sends_r;
  logic [1:0]         mode_active_r;
  logic signed [7:0]  mode_display_r;
  logic               clear_fault_r;
  logic               pid_reset_r;
  logic [14:0]        torque_out_r;

  logic               accept;
  sub_state_t         sub_start;
  logic [1:0]         sends;
  logic [1:0]         active;
  logic               pidr;
  logic               clear;
  logic               is_pos, is_vel;
  logic signed [32:0] vel_ext, lim_pos, lim_neg;
  logic signed [31:0] vel_clamped;
  logic [16:0]        count_inc;
  logic [15:0]        status_word;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Config port: index 3 falls through and is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      velocity_limit_r   <= VELOCITY_LIMIT_RST;
      torque_reference_r <= TORQUE_REFERENCE_RST;
      toggle_period_r    <= TOGGLE_PERIOD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_VELOCITY_LIMIT:   velocity_limit_r   <= cfg_wdata;
        CFG_TORQUE_REFERENCE: torque_reference_r <= cfg_wdata[14:0];
        CFG_TOGGLE_PERIOD:    toggle_period_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Symmetric clamp of the target velocity, done at 33 bits so -limit always fits
  always_comb begin
    vel_ext = 33'(in_target_velocity);
    lim_pos = $signed({2'b00, velocity_limit_r});
    lim_neg = -lim_pos;
    if (vel_ext > lim_pos) begin
      vel_clamped = lim_pos[31:0];
    end else if (vel_ext < lim_neg) begin
      vel_clamped = lim_neg[31:0];
    end else begin
      vel_clamped = in_target_velocity;
    end
  end

  // Sub-state machine
  always_comb begin
    clear = (in_control_word == CW_FAULT_RESET);
    sub_start = (in_control_word == CW_RESET || clear) ? SS_IDLE : sub_state_r;
    is_pos = (in_op_mode == MODE_PROFILE_POS);
    is_vel = (in_op_mode == MODE_PROFILE_VEL);

    sub_state_nxt  = sub_start;
    state_code_nxt = state_code_r;
    run_flag_nxt   = run_flag_r;
    held_speed_nxt = held_speed_r;
    sends          = 2'd0;
    pidr           = 1'b0;
    active         = is_pos ? ACT_POS : (is_vel ? ACT_VEL : ACT_NONE);

    if (is_pos || is_vel) begin
      unique case (sub_start)
        SS_IDLE: begin
          state_code_nxt = SC_SWITCH_ON_DISABLED;
          sends = 2'd1;
          if (is_vel) begin
            pidr = 1'b1;
            run_flag_nxt = 1'b0;
          end
          // quick stop in the velocity mode enters the second enable path
          if (is_vel && in_control_word == CW_QUICK_STOP) begin
            sub_state_nxt  = SS_ALT_DIS;
            state_code_nxt = SC_ALT_DISABLED;
            sends = 2'd2;
          end else if (in_control_word == CW_SHUTDOWN) begin
            sub_state_nxt = SS_READY;
          end
        end
        SS_READY: begin
          state_code_nxt = SC_READY;
          sends = 2'd1;
          sub_state_nxt = SS_SW_ON;
        end
        SS_SW_ON: begin
          if (in_control_word == CW_SWITCH_ON) begin
            sub_state_nxt  = SS_ENABLE;
            state_code_nxt = SC_SWITCHED_ON;
            sends = 2'd1;
          end
        end
        SS_ENABLE: begin
          if (in_control_word == CW_ENABLE_OP) begin
            sub_state_nxt  = SS_ENABLE2;
            state_code_nxt = SC_OP_ENABLED;
            sends = 2'd1;
          end
        end
        SS_ENABLE2: sub_state_nxt = SS_RUN;
        SS_RUN: begin
          sub_state_nxt  = SS_RUN_WAIT;
          state_code_nxt = SC_RUNNING;
          sends = 2'd1;
        end
        SS_RUN_WAIT: begin
          if (in_control_word == CW_QUICK_STOP) sub_state_nxt = SS_STOP;
          if (is_vel) begin
            run_flag_nxt   = 1'b1;
            held_speed_nxt = vel_clamped;
          end
        end
        SS_STOP: begin
          state_code_nxt = SC_QUICK_STOP;
          sends = 2'd1;
          sub_state_nxt = SS_STOP2;
        end
        SS_STOP2: sub_state_nxt = SS_STOP3;
        SS_STOP3: begin
          state_code_nxt = SC_STOPPED;
          sends = 2'd1;
          sub_state_nxt = SS_STOP4;
        end
        SS_STOP4: sub_state_nxt = SS_IDLE;
        // second enable path: velocity mode only, position mode parks here
        SS_ALT_DIS: begin
          if (is_vel && in_control_word == CW_SHUTDOWN) begin
            sub_state_nxt  = SS_ALT_READY;
            state_code_nxt = SC_ALT_READY;
            sends = 2'd1;
          end
        end
        SS_ALT_READY: begin
          if (is_vel && in_control_word == CW_SWITCH_ON) begin
            sub_state_nxt  = SS_ALT_SW_ON;
            state_code_nxt = SC_ALT_SWITCHED_ON;
            sends = 2'd1;
          end
        end
        SS_ALT_SW_ON: begin
          if (is_vel && in_control_word == CW_ENABLE_OP) begin
            sub_state_nxt  = SS_ALT_EN;
            state_code_nxt = SC_ALT_OP_ENABLED;
            sends = 2'd1;
          end
        end
        SS_ALT_EN: begin
          if (is_vel) sub_state_nxt = SS_ALT_EN2;
        end
        SS_ALT_EN2: begin
          if (is_vel) begin
            sub_state_nxt  = SS_RUN_WAIT;
            state_code_nxt = SC_ALT_RUNNING;
            sends = 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Status toggle: a period of 0 or 1 flips every tick; 17-bit count catches wrap
  always_comb begin
    count_inc = {1'b0, toggle_count_r} + 17'd1;
    if (count_inc >= {1'b0, toggle_period_r}) begin
      toggle_bit_nxt   = !toggle_bit_r;
      toggle_count_nxt = 16'd0;
    end else begin
      toggle_bit_nxt   = toggle_bit_r;
      toggle_count_nxt = count_inc[15:0];
    end
    status_word = {1'b0, toggle_bit_nxt, 1'b0, state_code_nxt}
                | {12'd0, in_fault_active, 3'd0};
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_state_r    <= SS_IDLE;
      state_code_r   <= '0;
      toggle_bit_r   <= 1'b1;
      toggle_count_r <= 16'd1;
      held_speed_r   <= '0;
      run_flag_r     <= 1'b0;
    end else if (accept) begin
      sub_state_r    <= sub_state_nxt;
      state_code_r   <= state_code_nxt;
      toggle_bit_r   <= toggle_bit_nxt;
      toggle_count_r <= toggle_count_nxt;
      held_speed_r   <= held_speed_nxt;
      run_flag_r     <= run_flag_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_word_r  <= status_word;
      status_sends_r <= sends;
      mode_active_r  <= active;
      mode_display_r <= in_op_mode;
      clear_fault_r  <= clear;
      pid_reset_r    <= pidr;
      torque_out_r   <= run_flag_nxt ? torque_reference_r : 15'd0;
    end
  end

  // speed and run flag come straight from the state registers
  assign out_valid           = out_valid_r;
  assign out_status_word     = status_word_r;
  assign out_status_sends    = status_sends_r;
  assign out_mode_active     = mode_active_r;
  assign out_mode_display    = mode_display_r;
  assign out_speed_reference = held_speed_r;
  assign out_drive_run       = run_flag_r;
  assign out_torque_out      = torque_out_r;
  assign out_clear_fault     = clear_fault_r;
  assign out_pid_reset       = pid_reset_r;

endmodule

`default_nettype wire
